// ----- src/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Field widths, action and status codes, and the result status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int ACT_W = 3;
    localparam int POS_W = 7;
    localparam int CNT_W = 7;
    localparam int SUM_W = 38;
    localparam int ST_W  = 2;

    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_AT    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_BACK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_AT    = 3'd5;
    localparam logic [ACT_W-1:0] ACT_FIND      = 3'd6;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] even_count;
        logic [CNT_W-1:0] odd_count;
        logic [CNT_W-1:0] first_pos;
        logic [CNT_W-1:0] last_pos;
        logic [CNT_W-1:0] occurrences;
    } ple_stat_t;

endpackage

`default_nettype wire

// ----- src/ple_req_if.sv -----
// ----------------------------------------------------------------------------
// ple_req_if: request channel
// Valid/ready channel carrying one list action.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_req_if #(
    parameter int VALUE_WIDTH = ple_pkg::DEF_VALUE_WIDTH
) ();
    import ple_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [ACT_W-1:0]              action;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [POS_W-1:0]              position;

    modport source (output valid, output action, output value, output position,
                    input ready);
    modport sink   (input valid, input action, input value, input position,
                    output ready);
endinterface

`default_nettype wire

// ----- src/ple_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ple_rsp_if: response channel
// Valid/ready channel carrying one result of a list action.
// ----------------------------------------------------------------------------
`default_nettype none

interface ple_rsp_if #(
    parameter int VALUE_WIDTH = ple_pkg::DEF_VALUE_WIDTH
) ();
    import ple_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [ST_W-1:0]               status;
    logic [CNT_W-1:0]              entry_count;
    logic signed [SUM_W-1:0]       total;
    logic [CNT_W-1:0]              even_count;
    logic [CNT_W-1:0]              odd_count;
    logic signed [VALUE_WIDTH-1:0] middle_value;
    logic [CNT_W-1:0]              first_pos;
    logic [CNT_W-1:0]              last_pos;
    logic [CNT_W-1:0]              occurrences;

    modport source (output valid, output status, output entry_count, output total,
                    output even_count, output odd_count, output middle_value,
                    output first_pos, output last_pos, output occurrences,
                    input ready);
    modport sink   (input valid, input status, input entry_count, input total,
                    input even_count, input odd_count, input middle_value,
                    input first_pos, input last_pos, input occurrences,
                    output ready);
endinterface

`default_nettype wire

// ----- src/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list of signed values
// Insert, delete and find by position or key, with running count, sum,
// parity tallies and middle element reported for every action.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                   | transfer when
//  --------+-----+-------------------------------------------+----------------
//  req     | in  | action, value, position                   | valid & ready
//  rsp     | out | status, entry_count, total, even/odd,     | valid & ready
//          |     | middle_value, first_pos, last_pos, occur. |
//
// Each action walks the entries it touches: an insert shifts the entries from
//   its position to the end up by one, a delete moves those after the victim
//   down by one, and a find reads every entry; a rejected action or an empty find skips the walk.
// The walk does one RAM read and one write a cycle, with registered read data;
//   req is not ready until the core's result is taken.
// Reset clears the count, sum and tallies; entries need no clearing since
//   only entries below the count are ever read.
// A result sits in the rsp register while the next req is taken; the core
//   holds its finished result until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
    parameter int CAPACITY    = ple_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ple_pkg::DEF_VALUE_WIDTH
) (
    input wire logic clk,
    input wire logic rst_n,
    ple_req_if.sink  req,
    ple_rsp_if.source rsp
);
    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    // core to RAM
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    // core result
    logic                          res_valid;
    logic                          res_ready;
    ple_stat_t                     res_stat;
    logic signed [SUM_W-1:0]       res_total;
    logic signed [VALUE_WIDTH-1:0] res_middle;

    // rsp output register
    logic                          out_vld_reg,  out_vld_next;
    ple_stat_t                     out_stat_reg;
    logic signed [SUM_W-1:0]       out_total_reg;
    logic signed [VALUE_WIDTH-1:0] out_mid_reg;

    ple_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ple_core #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .in_action   (req.action),
        .in_value    (req.value),
        .in_position (req.position),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_stat    (res_stat),
        .res_total   (res_total),
        .res_middle  (res_middle),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // slot is free when empty or being drained this cycle
    assign res_ready = !out_vld_reg || rsp.ready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (res_valid && res_ready)
            out_vld_next = 1'b1;
        else if (rsp.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_stat_reg  <= res_stat;
            out_total_reg <= res_total;
            out_mid_reg   <= res_middle;
        end
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.status       = out_stat_reg.status;
    assign rsp.entry_count  = out_stat_reg.entry_count;
    assign rsp.total        = out_total_reg;
    assign rsp.even_count   = out_stat_reg.even_count;
    assign rsp.odd_count    = out_stat_reg.odd_count;
    assign rsp.middle_value = out_mid_reg;
    assign rsp.first_pos    = out_stat_reg.first_pos;
    assign rsp.last_pos     = out_stat_reg.last_pos;
    assign rsp.occurrences  = out_stat_reg.occurrences;

endmodule

`default_nettype wire

// ----- src/ple_ram.sv -----
// ----------------------------------------------------------------------------
// ple_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

// ----- src/ple_core.sv -----
// ----------------------------------------------------------------------------
// ple_core: list sequencer and accounting
// Walks the entry RAM one entry per cycle to shift or search, then keeps
// count, sum and parity tallies and fetches the middle entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_core #(
    parameter int CAPACITY    = ple_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ple_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire logic [ple_pkg::ACT_W-1:0]           in_action,
    input  wire logic signed [VALUE_WIDTH-1:0]       in_value,
    input  wire logic [ple_pkg::POS_W-1:0]           in_position,
    output      logic                                res_valid,
    input  wire logic                                res_ready,
    output      ple_pkg::ple_stat_t                  res_stat,
    output      logic signed [ple_pkg::SUM_W-1:0]    res_total,
    output      logic signed [VALUE_WIDTH-1:0]       res_middle,
    output      logic                                ram_we,
    output      logic [$clog2(CAPACITY)-1:0]         ram_waddr,
    output      logic [VALUE_WIDTH-1:0]              ram_wdata,
    output      logic                                ram_re,
    output      logic [$clog2(CAPACITY)-1:0]         ram_raddr,
    input  wire logic [VALUE_WIDTH-1:0]              ram_rdata
);
    import ple_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = ((LW > POS_W) ? LW : POS_W) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_ACCT = 3'd3;
    localparam logic [2:0] S_MID  = 3'd4;
    localparam logic [2:0] S_MIDW = 3'd5;

    logic [2:0]                    state_reg,    state_next;
    logic [ACT_W-1:0]              act_reg,      act_next;
    logic signed [VALUE_WIDTH-1:0] value_reg,    value_next;
    logic [AW-1:0]                 idx_reg,      idx_next;
    logic [ST_W-1:0]               status_reg,   status_next;
    logic                          rd_act_reg,   rd_act_next;
    logic [AW-1:0]                 rd_ptr_reg,   rd_ptr_next;
    logic [AW-1:0]                 rd_end_reg,   rd_end_next;
    logic                          pend_vld_reg, pend_vld_next;
    logic [AW-1:0]                 pend_addr_reg, pend_addr_next;
    logic signed [VALUE_WIDTH-1:0] removed_reg,  removed_next;
    logic [LW-1:0]                 first_reg,    first_next;
    logic [LW-1:0]                 last_reg,     last_next;
    logic [LW-1:0]                 occ_reg,      occ_next;
    logic [LW-1:0]                 length_reg,   length_next;
    logic signed [SUM_W-1:0]       sum_reg,      sum_next;
    logic [LW-1:0]                 even_reg,     even_next;

    // accept-time decode
    logic [XW-1:0]   len_x;
    logic [XW-1:0]   pos_x;
    logic            is_full;
    logic            is_empty;
    logic [ST_W-1:0] dec_status;
    logic [AW-1:0]   dec_idx;
    logic            act_ins;
    logic            act_del;
    logic            act_find;
    logic [LW-1:0]   hit_pos;

    assign len_x    = XW'(length_reg);
    assign pos_x    = XW'(in_position);
    assign is_full  = (length_reg == LW'(CAPACITY));
    assign is_empty = (length_reg == '0);
    assign act_ins  = act_reg inside {ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT};
    assign act_del  = act_reg inside {ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT};
    assign act_find = (act_reg == ACT_FIND);
    assign hit_pos  = LW'(pend_addr_reg) + LW'(1);

    always_comb
    begin
        dec_status = ST_OK;
        dec_idx    = '0;
        case (in_action)
            ACT_INS_FRONT:
            begin
                if (is_full)
                    dec_status = ST_FULL;
            end
            ACT_INS_BACK:
            begin
                dec_idx = AW'(length_reg);
                if (is_full)
                    dec_status = ST_FULL;
            end
            ACT_INS_AT:
            begin
                dec_idx = AW'(pos_x - XW'(1));
                if (pos_x == '0 || pos_x > len_x + XW'(1))
                    dec_status = ST_BAD_POS;
                else if (is_full)
                    dec_status = ST_FULL;
            end
            ACT_DEL_FRONT:
            begin
                if (is_empty)
                    dec_status = ST_EMPTY;
            end
            ACT_DEL_BACK:
            begin
                dec_idx = AW'(length_reg - LW'(1));
                if (is_empty)
                    dec_status = ST_EMPTY;
            end
            ACT_DEL_AT:
            begin
                dec_idx = AW'(pos_x - XW'(1));
                if (pos_x == '0 || pos_x > len_x)
                    dec_status = ST_BAD_POS;
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        rd_act_next    = rd_act_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_end_next    = rd_end_reg;
        pend_vld_next  = 1'b0;
        pend_addr_next = pend_addr_reg;
        removed_next   = removed_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        occ_next       = occ_reg;
        length_next    = length_reg;
        sum_next       = sum_reg;
        even_next      = even_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = rd_ptr_reg;
        in_ready       = (state_reg == S_IDLE);
        res_valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next    = in_action;
                    value_next  = in_value;
                    idx_next    = dec_idx;
                    status_next = dec_status;
                    first_next  = '0;
                    last_next   = '0;
                    occ_next    = '0;
                    state_next  = S_MID;
                    if (dec_status == ST_OK)
                    begin
                        if (in_action inside {ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT})
                        begin
                            // shift tail up by one, walking from the end down
                            if (LW'(dec_idx) < length_reg)
                            begin
                                rd_ptr_next = AW'(length_reg - LW'(1));
                                rd_end_next = dec_idx;
                                rd_act_next = 1'b1;
                                state_next  = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        else if (in_action inside {ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT})
                        begin
                            // first read is the victim, the rest move down
                            rd_ptr_next = dec_idx;
                            rd_end_next = AW'(length_reg - LW'(1));
                            rd_act_next = 1'b1;
                            state_next  = S_SCAN;
                        end
                        else if (in_action == ACT_FIND && !is_empty)
                        begin
                            rd_ptr_next = '0;
                            rd_end_next = AW'(length_reg - LW'(1));
                            rd_act_next = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_act_reg)
                begin
                    ram_re         = 1'b1;
                    pend_vld_next  = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    if (rd_ptr_reg == rd_end_reg)
                        rd_act_next = 1'b0;
                    else if (act_ins)
                        rd_ptr_next = rd_ptr_reg - AW'(1);
                    else
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                end
                if (pend_vld_reg)
                begin
                    if (act_ins)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pend_addr_reg + AW'(1);
                    end
                    else if (act_del)
                    begin
                        if (pend_addr_reg == idx_reg)
                        begin
                            removed_next = ram_rdata;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pend_addr_reg - AW'(1);
                        end
                    end
                    else if (act_find && ram_rdata == value_reg)
                    begin
                        if (occ_reg == '0)
                            first_next = hit_pos;
                        last_next = hit_pos;
                        occ_next  = occ_reg + LW'(1);
                    end
                end
                // last read is in flight: it is handled this cycle
                if (!rd_act_reg)
                begin
                    if (act_ins)
                        state_next = S_PUT;
                    else if (act_del)
                        state_next = S_ACCT;
                    else
                        state_next = S_MID;
                end
            end
            S_PUT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = idx_reg;
                ram_wdata   = value_reg;
                length_next = length_reg + LW'(1);
                sum_next    = sum_reg + SUM_W'(value_reg);
                if (!value_reg[0])
                    even_next = even_reg + LW'(1);
                state_next  = S_MID;
            end
            S_ACCT:
            begin
                length_next = length_reg - LW'(1);
                sum_next    = sum_reg - SUM_W'(removed_reg);
                if (!removed_reg[0])
                    even_next = even_reg - LW'(1);
                state_next  = S_MID;
            end
            S_MID:
            begin
                ram_re     = !is_empty;
                ram_raddr  = AW'(length_reg >> 1);
                state_next = S_MIDW;
            end
            S_MIDW:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_stat.status      = status_reg;
    assign res_stat.entry_count = CNT_W'(length_reg);
    assign res_stat.even_count  = CNT_W'(even_reg);
    assign res_stat.odd_count   = CNT_W'(length_reg - even_reg);
    assign res_stat.first_pos   = CNT_W'(first_reg);
    assign res_stat.last_pos    = CNT_W'(last_reg);
    assign res_stat.occurrences = CNT_W'(occ_reg);
    assign res_total            = sum_reg;
    assign res_middle           = is_empty ? '0 : ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_act_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            length_reg   <= '0;
            sum_reg      <= '0;
            even_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_act_reg   <= rd_act_next;
            pend_vld_reg <= pend_vld_next;
            length_reg   <= length_next;
            sum_reg      <= sum_next;
            even_reg     <= even_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        value_reg     <= value_next;
        idx_reg       <= idx_next;
        status_reg    <= status_next;
        rd_ptr_reg    <= rd_ptr_next;
        rd_end_reg    <= rd_end_next;
        pend_addr_reg <= pend_addr_next;
        removed_reg   <= removed_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        occ_reg       <= occ_next;
    end

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(CAPACITY))
        else $error("entry count above capacity");

    a_even_bound: assert property (@(posedge clk) disable iff (!rst_n)
        even_reg <= length_reg)
        else $error("even tally above entry count");

    a_len_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_PUT && state_reg != S_ACCT) |=> $stable(length_reg))
        else $error("entry count moved outside accounting step");

    a_find_order: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && occ_reg != '0) |-> (first_reg != '0 && first_reg <= last_reg))
        else $error("find positions inconsistent");
`endif

endmodule

`default_nettype wire
